// File: sv/pce_pkg.sv
// Shared types, character codes and the microcode store of the conversion emitter.
package pce_pkg;

    // Conversion modes carried in the func field
    localparam logic [1:0] FUNC_CHAR = 2'd0;
    localparam logic [1:0] FUNC_DEC  = 2'd1;
    localparam logic [1:0] FUNC_STR  = 2'd2;
    localparam logic [1:0] FUNC_NULL = 2'd3;

    // Character codes
    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_MINUS = 8'h2D;
    localparam logic [7:0] CHR_LPAR  = 8'h28;

    // Datapath geometry
    localparam int MAG_W      = 32;
    localparam int DIGITS     = 10;
    localparam int BCD_W      = 4 * DIGITS;
    localparam int NULL_LEN   = 6;
    localparam int PC_W       = 4;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [31:0] value;
    } t_pce_in;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last;
    } t_pce_out;

    // Datapath operations, one per microinstruction
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,       // take an input transaction
        OP_PREP,       // split sign and magnitude, clear BCD
        OP_EMIT_LOW,   // emit low byte as the last character
        OP_EMIT_STR,   // as above, but nothing for a zero byte
        OP_SIGN,       // emit '-' when negative
        OP_DABBLE,     // one shift-add-3 step
        OP_ALIGN,      // drop one leading zero digit
        OP_DIGIT,      // emit the top digit and shift
        OP_NCLR,       // reset the text index
        OP_NULL        // emit one character of "(null)"
    } t_pce_op;

    // Sequencing conditions
    typedef enum logic [1:0] {
        CND_NEXT,      // step counter + 1
        CND_GOTO,      // unconditional jump
        CND_DISPATCH,  // jump to target + func
        CND_WHILE      // jump to target while the datapath reports more
    } t_pce_cond;

    typedef struct packed {
        t_pce_op           op;
        t_pce_cond         cond;
        logic [PC_W-1:0]   target;
    } t_pce_uword;

    // Status from datapath back to the sequencer
    typedef struct packed {
        logic       go;    // current step can complete this cycle
        logic       more;  // loop condition of the current step
        logic [1:0] func;  // mode of the transaction in hand
    } t_pce_stat;

    // Step addresses
    localparam logic [PC_W-1:0] PC_IDLE  = 4'd0;
    localparam logic [PC_W-1:0] PC_DISP  = 4'd1;
    localparam logic [PC_W-1:0] PC_SIGN  = 4'd5;
    localparam logic [PC_W-1:0] PC_DAB   = 4'd6;
    localparam logic [PC_W-1:0] PC_ALIGN = 4'd7;
    localparam logic [PC_W-1:0] PC_DIGIT = 4'd8;
    localparam logic [PC_W-1:0] PC_NULL  = 4'd10;

    // Microcode store
    function automatic t_pce_uword pce_rom(input logic [PC_W-1:0] pc);
        t_pce_uword w;
        w = '{op: OP_NOP, cond: CND_GOTO, target: PC_IDLE};
        case (pc)
            4'd0:  w = '{op: OP_LOAD,     cond: CND_DISPATCH, target: PC_DISP};
            4'd1:  w = '{op: OP_EMIT_LOW, cond: CND_GOTO,     target: PC_IDLE};
            4'd2:  w = '{op: OP_PREP,     cond: CND_GOTO,     target: PC_SIGN};
            4'd3:  w = '{op: OP_EMIT_STR, cond: CND_GOTO,     target: PC_IDLE};
            4'd4:  w = '{op: OP_NCLR,     cond: CND_GOTO,     target: PC_NULL};
            4'd5:  w = '{op: OP_SIGN,     cond: CND_NEXT,     target: PC_IDLE};
            4'd6:  w = '{op: OP_DABBLE,   cond: CND_WHILE,    target: PC_DAB};
            4'd7:  w = '{op: OP_ALIGN,    cond: CND_WHILE,    target: PC_ALIGN};
            4'd8:  w = '{op: OP_DIGIT,    cond: CND_WHILE,    target: PC_DIGIT};
            4'd9:  w = '{op: OP_NOP,      cond: CND_GOTO,     target: PC_IDLE};
            4'd10: w = '{op: OP_NULL,     cond: CND_WHILE,    target: PC_NULL};
            4'd11: w = '{op: OP_NOP,      cond: CND_GOTO,     target: PC_IDLE};
            default: w = '{op: OP_NOP,    cond: CND_GOTO,     target: PC_IDLE};
        endcase
        return w;
    endfunction

    // Text of a null string conversion
    function automatic logic [7:0] pce_null_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = CHR_LPAR;
            3'd1:    c = 8'h6E;
            3'd2:    c = 8'h75;
            3'd3:    c = 8'h6C;
            3'd4:    c = 8'h6C;
            3'd5:    c = 8'h29;
            default: c = CHR_LPAR;
        endcase
        return c;
    endfunction

endpackage

// File: sv/pce_useq.sv
// Microcode sequencer: step counter, control store and jump logic.
module pce_useq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pce_pkg::t_pce_stat  i_stat,
    output pce_pkg::t_pce_uword o_uword
);
    import pce_pkg::*;

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    t_pce_uword      uw;

    // Fetch the current control word
    always_comb begin
        uw = pce_rom(r_pc);
    end

    assign o_uword = uw;

    // Select the next step; hold while the datapath cannot complete
    always_comb begin
        n_pc = r_pc;
        if (i_stat.go) begin
            case (uw.cond)
                CND_NEXT:     n_pc = r_pc + 1'b1;
                CND_GOTO:     n_pc = uw.target;
                CND_DISPATCH: n_pc = uw.target + {{(PC_W-2){1'b0}}, i_stat.func};
                CND_WHILE:    n_pc = i_stat.more ? uw.target : r_pc + 1'b1;
                default:      n_pc = PC_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

// File: sv/pce_datapath.sv
// Datapath: operand registers, shift-add-3 converter, digit emitter and output register.
module pce_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pce_pkg::t_pce_uword i_uword,
    output pce_pkg::t_pce_stat  o_stat,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  pce_pkg::t_pce_in    i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output pce_pkg::t_pce_out   o_out_data
);
    import pce_pkg::*;

    logic [1:0]       r_func, n_func;
    logic [31:0]      r_val, n_val;
    logic             r_neg, n_neg;
    logic [MAG_W-1:0] r_mag, n_mag;
    logic [BCD_W-1:0] r_bcd, n_bcd;
    logic [5:0]       r_cnt, n_cnt;
    logic [3:0]       r_dig, n_dig;
    logic             r_ovalid, n_ovalid;
    t_pce_out         r_out, n_out;

    logic             slot_free;
    logic             top_zero;
    logic [BCD_W-1:0] bcd_adj;

    assign slot_free  = !r_ovalid || !i_out_stall;
    assign top_zero   = (r_bcd[BCD_W-1 -: 4] == 4'd0);
    assign o_in_stall = (i_uword.op != OP_LOAD);

    // Add 3 to every digit of 5 or more ahead of the shift
    always_comb begin
        for (int d = 0; d < DIGITS; d++) begin
            bcd_adj[4*d +: 4] = (r_bcd[4*d +: 4] >= 4'd5) ? r_bcd[4*d +: 4] + 4'd3
                                                          : r_bcd[4*d +: 4];
        end
    end

    // Report whether the step completes and whether its loop continues
    always_comb begin
        o_stat.func = r_func;
        o_stat.go   = 1'b1;
        o_stat.more = 1'b0;
        case (i_uword.op)
            OP_LOAD: begin
                // dispatch on the mode of the transaction being taken
                o_stat.go   = i_in_valid;
                o_stat.func = i_in_data.func;
            end
            OP_EMIT_LOW,
            OP_EMIT_STR,
            OP_SIGN:     o_stat.go = slot_free;
            OP_DABBLE:   o_stat.more = (r_cnt != 6'd1);
            OP_ALIGN:    o_stat.more = top_zero && (r_dig != 4'd1);
            OP_DIGIT: begin
                o_stat.go   = slot_free;
                o_stat.more = (r_dig != 4'd1);
            end
            OP_NULL: begin
                o_stat.go   = slot_free;
                o_stat.more = (r_cnt[2:0] != 3'(NULL_LEN - 1));
            end
            default: o_stat.go = 1'b1;
        endcase
    end

    // Execute the current operation
    always_comb begin
        n_func   = r_func;
        n_val    = r_val;
        n_neg    = r_neg;
        n_mag    = r_mag;
        n_bcd    = r_bcd;
        n_cnt    = r_cnt;
        n_dig    = r_dig;
        n_ovalid = r_ovalid && i_out_stall;
        n_out    = r_out;
        case (i_uword.op)
            OP_LOAD: begin
                if (i_in_valid) begin
                    n_func = i_in_data.func;
                    n_val  = i_in_data.value;
                end
            end
            OP_PREP: begin
                n_neg = r_val[31];
                n_mag = r_val[31] ? (32'd0 - r_val) : r_val;
                n_bcd = '0;
                n_cnt = 6'(MAG_W);
                n_dig = 4'(DIGITS);
            end
            OP_EMIT_LOW: begin
                if (slot_free) begin
                    n_ovalid = 1'b1;
                    n_out    = '{out_char: r_val[7:0], last: 1'b1};
                end
            end
            OP_EMIT_STR: begin
                if (slot_free && (r_val[7:0] != 8'd0)) begin
                    n_ovalid = 1'b1;
                    n_out    = '{out_char: r_val[7:0], last: 1'b1};
                end
            end
            OP_SIGN: begin
                if (slot_free && r_neg) begin
                    n_ovalid = 1'b1;
                    n_out    = '{out_char: CHR_MINUS, last: 1'b0};
                end
            end
            OP_DABBLE: begin
                {n_bcd, n_mag} = {bcd_adj[BCD_W-2:0], r_mag, 1'b0};
                n_cnt          = r_cnt - 6'd1;
            end
            OP_ALIGN: begin
                if (top_zero && (r_dig != 4'd1)) begin
                    n_bcd = {r_bcd[BCD_W-5:0], 4'd0};
                    n_dig = r_dig - 4'd1;
                end
            end
            OP_DIGIT: begin
                if (slot_free) begin
                    n_ovalid = 1'b1;
                    n_out    = '{out_char: CHR_ZERO + {4'd0, r_bcd[BCD_W-1 -: 4]},
                                 last: (r_dig == 4'd1)};
                    n_bcd    = {r_bcd[BCD_W-5:0], 4'd0};
                    n_dig    = r_dig - 4'd1;
                end
            end
            OP_NCLR: n_cnt = 6'd0;
            OP_NULL: begin
                if (slot_free) begin
                    n_ovalid = 1'b1;
                    n_out    = '{out_char: pce_null_char(r_cnt[2:0]),
                                 last: (r_cnt[2:0] == 3'(NULL_LEN - 1))};
                    n_cnt    = r_cnt + 6'd1;
                end
            end
            default: n_ovalid = r_ovalid && i_out_stall;
        endcase
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_func <= n_func;
        r_val  <= n_val;
        r_neg  <= n_neg;
        r_mag  <= n_mag;
        r_bcd  <= n_bcd;
        r_cnt  <= n_cnt;
        r_dig  <= n_dig;
        r_out  <= n_out;
    end

    // Output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else begin
            r_ovalid <= n_ovalid;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

endmodule

// File: sv/printf_conversion_emitter.sv
// Top level of the printf-style conversion emitter.
// Accepts one conversion request (func, value) at a time and delivers its ASCII characters,
// one output transaction each, flagging the last. A char request runs a load and an emit step,
// a string byte the same, and a null string a load, an index clear, six characters and one
// closing step. A signed decimal runs one load, one sign/magnitude split, one sign step,
// 32 shift-add-3 steps through the single BCD adjust unit, leading-zero alignment steps,
// one step per digit and one closing step. Control is a 12-step microprogram; the input is
// taken only while the sequencer sits at its load step, and an output stall while a character
// is still pending holds the sequencer on its emitting step.
module printf_conversion_emitter (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  pce_pkg::t_pce_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output pce_pkg::t_pce_out o_out_data
);
    import pce_pkg::*;

    t_pce_uword uword;
    t_pce_stat  stat;

    // Sequence the microprogram
    pce_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_uword (uword)
    );

    // Carry out each step
    pce_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_uword     (uword),
        .o_stat      (stat),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// File: tb/sv/printf_conversion_emitter_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of the printf-style conversion emitter with its own character predictor.
module printf_conversion_emitter_tb;
    import pce_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int MAX_GAP      = 18;
    localparam int DRAIN_CYCLES = 64;
    localparam int LONG_HOLD    = 300;

    localparam logic [7:0] NULL_TEXT [6] = '{"(", "n", "u", "l", "l", ")"};

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_stall;
    t_pce_in  in_data;
    logic     out_valid;
    logic     out_stall;
    t_pce_out out_data;

    t_pce_out    expected_chars [$];
    t_pce_out    want;
    int unsigned mismatches;
    int unsigned cycle_count;
    bit          idle_on;
    int          hold_request;

    printf_conversion_emitter dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    // Free-running clock, 4 ns period
    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Work out the characters one conversion request prints
    function automatic void predict_conversion(input t_pce_in req);
        logic [7:0]  text [$];
        logic [7:0]  digits [10];
        logic [31:0] mag;
        logic [7:0]  low;
        int          nd;
        low = req.value[7:0];
        case (req.func)
            FUNC_CHAR: text.push_back(low);
            FUNC_DEC: begin
                mag = req.value;
                if (req.value[31]) begin
                    text.push_back(CHR_MINUS);
                    mag = -mag;
                end
                nd = 0;
                do begin
                    digits[nd] = CHR_ZERO + 8'(mag % 10);
                    nd++;
                    mag = mag / 10;
                end while (mag != 0 && nd < 10);
                while (nd > 0) begin
                    nd--;
                    text.push_back(digits[nd]);
                end
            end
            FUNC_STR: begin
                // a terminator prints nothing
                if (low != 8'h00) text.push_back(low);
            end
            default: foreach (NULL_TEXT[k]) text.push_back(NULL_TEXT[k]);
        endcase
        foreach (text[k])
            expected_chars.push_back('{out_char: text[k], last: (k == text.size() - 1)});
    endfunction

    // Offer one request after a random gap; return at the edge that accepts it, valid still high
    task automatic send_request(input logic [1:0] func, input logic [31:0] value);
        int gap;
        gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
        @(negedge clk);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid      = 1'b1;
        in_data.func  = func;
        in_data.value = value;
        do @(posedge clk); while (in_stall);
        predict_conversion(in_data);
    endtask

    // Drop valid and hold until every expected character has arrived
    task automatic wait_drain;
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_chars.size() != 0) @(posedge clk);
    endtask

    task automatic test_char_conversions;
        send_request(FUNC_CHAR, 32'h0000_0000);   // NUL is still printed
        send_request(FUNC_CHAR, 32'h0000_00FF);
        send_request(FUNC_CHAR, 32'h0000_0041);
        send_request(FUNC_CHAR, 32'hFFFF_FF41);   // upper bits ignored
        send_request(FUNC_CHAR, 32'h8000_0000);
    endtask

    task automatic test_decimal_conversions;
        send_request(FUNC_DEC, 32'd0);
        send_request(FUNC_DEC, 32'd1);
        send_request(FUNC_DEC, -32'sd1);
        send_request(FUNC_DEC, 32'd9);
        send_request(FUNC_DEC, 32'd10);
        send_request(FUNC_DEC, -32'sd10);
        send_request(FUNC_DEC, 32'h7FFF_FFFF);
        send_request(FUNC_DEC, 32'h8000_0000);    // most negative value
        send_request(FUNC_DEC, 32'd1000000000);
        send_request(FUNC_DEC, 32'd2000000000);
        send_request(FUNC_DEC, -32'sd999999999);
        send_request(FUNC_DEC, 32'hAAAA_5555);
    endtask

    task automatic test_string_bytes;
        send_request(FUNC_STR, 32'h0000_0000);    // terminator
        send_request(FUNC_STR, 32'hFFFF_FF00);    // terminator with upper bits set
        send_request(FUNC_STR, 32'h0000_007F);
        send_request(FUNC_STR, 32'h0000_00FF);
        send_request(FUNC_STR, {24'($urandom_range(0, 16777215)), 8'h68});
    endtask

    task automatic test_null_strings;
        send_request(FUNC_NULL, 32'h0000_0000);
        send_request(FUNC_NULL, 32'hFFFF_FFFF);
    endtask

    // Random requests, with bursts of string walks ending in a terminator
    task automatic test_random_conversions(input int count);
        int          i;
        int          len;
        logic [1:0]  func;
        logic [31:0] v;
        i = 0;
        while (i < count) begin
            if ($urandom_range(0, 5) == 0) begin
                len = $urandom_range(1, 6);
                repeat (len) begin
                    v = $urandom;
                    v[7:0] = 8'($urandom_range(1, 255));
                    send_request(FUNC_STR, v);
                end
                v = $urandom;
                v[7:0] = 8'h00;
                send_request(FUNC_STR, v);
                i += len + 1;
            end else begin
                func = 2'($urandom_range(0, 3));
                case ($urandom_range(0, 3))
                    0: v = $urandom;
                    1: begin
                        v = $urandom_range(0, 20);
                        if ($urandom_range(0, 1) == 1) v = -v;
                    end
                    2: v = ($urandom_range(0, 1) == 1) ? 32'h7FFF_FFFF - $urandom_range(0, 3)
                                                       : 32'h8000_0000 + $urandom_range(0, 3);
                    default: v = $urandom >> $urandom_range(0, 31);
                endcase
                send_request(func, v);
                i++;
            end
        end
    endtask

    // Hold the output off for a long stretch while requests keep coming
    task automatic test_output_back_pressure;
        hold_request = LONG_HOLD;
        idle_on      = 1'b0;
        repeat (16) send_request(2'($urandom_range(0, 3)), $urandom);
        idle_on = 1'b1;
        wait_drain();
    endtask

    // Run both sides without gaps
    task automatic test_full_rate;
        idle_on = 1'b0;
        repeat (20) send_request(2'($urandom_range(0, 3)), $urandom);
        idle_on = 1'b1;
        wait_drain();
    endtask

    // Receiver: random stall before each transaction, or a long hold when asked
    initial begin : output_receiver
        int w;
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            w = idle_on ? $urandom_range(0, MAX_GAP) : 0;
            if (hold_request > 0) begin
                w = hold_request;
                hold_request = 0;
            end
            if (w > 0) begin
                out_stall = 1'b1;
                repeat (w) @(negedge clk);
                out_stall = 1'b0;
            end
            do @(posedge clk); while (!(rst_n && out_valid));
        end
    end

    // Compare each output transaction with the oldest expected character
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (expected_chars.size() == 0) begin
                $error("unexpected output transaction: out_char %h, last %b",
                       out_data.out_char, out_data.last);
                mismatches++;
            end else begin
                want = expected_chars.pop_front();
                if (out_data.out_char !== want.out_char) begin
                    $error("out_char: expected %h, actual %h", want.out_char, out_data.out_char);
                    mismatches++;
                end
                if (out_data.last !== want.last) begin
                    $error("last: expected %b, actual %b", want.last, out_data.last);
                    mismatches++;
                end
            end
        end
    end

    // Abort a run that hangs
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[printf_conversion_emitter] ERROR");
        $finish;
    end

    initial begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        mismatches   = 0;
        idle_on      = 1'b1;
        hold_request = 0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        test_char_conversions();
        test_decimal_conversions();
        test_string_bytes();
        test_null_strings();
        wait_drain();
        test_random_conversions(70);
        wait_drain();
        test_output_back_pressure();
        test_full_rate();

        // Let any late transaction show up before the verdict
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_chars.size() == 0) begin
            $display("[printf_conversion_emitter] OK");
        end else begin
            $display("[printf_conversion_emitter] ERROR");
        end
        $finish;
    end

endmodule
